// ===== hdl/rhbp_pkg.sv =====
// shared types and constants for the rtsp header block parser
`timescale 1ns / 1ps

package rhbp_pkg;

    localparam int POSITION_BITS = 16;
    localparam int MAX_HEADERS   = 64;

    // position counter carries one extra bit so it can sit at the limit plus one
    localparam int POS_W = POSITION_BITS + 1;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'((64'd1 << POSITION_BITS) - 64'd1);
    localparam logic [POS_W-1:0] POS_STOP  = POS_W'(64'd1 << POSITION_BITS);

    localparam int CAP_W   = 7;
    localparam int INDEX_W = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_HEADERS);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int VALUE_GAP = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE            = 3'd0,
        ERR_NOT_ENOUGH_DATA = 3'd1,
        ERR_MISSING_CRLF    = 3'd2,
        ERR_INVALID_HEADER  = 3'd3,
        ERR_EXCESS_HEADERS  = 3'd4,
        ERR_TOO_LONG        = 3'd5
    } error_t;

    typedef enum logic [1:0] {
        PH_LINE = 2'd0,
        PH_CR   = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef struct packed {
        kind_t                    result_kind;
        error_t                   error_code;
        logic [INDEX_W-1:0]       header_index;
        logic [POSITION_BITS-1:0] key_start;
        logic [POSITION_BITS-1:0] key_length;
        logic [POSITION_BITS-1:0] value_start;
        logic [POSITION_BITS-1:0] value_length;
        logic [POSITION_BITS-1:0] bytes_consumed;
        logic                     last_of_run;
    } result_t;

    typedef struct packed {
        logic push0;
        logic push1;
    } fifo_push_t;

    typedef struct packed {
        logic room;
    } fifo_status_t;

    function automatic result_t make_error(error_t code);
        result_t r;
        r                = '0;
        r.result_kind    = KIND_ERROR;
        r.error_code     = code;
        return r;
    endfunction

endpackage

// ===== hdl/rhbp_stream_if.sv =====
// byte stream channel into the parser
`timescale 1ns / 1ps

interface rhbp_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== hdl/rhbp_result_if.sv =====
// result channel out of the parser
`timescale 1ns / 1ps

interface rhbp_result_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          result_kind;
    logic [2:0]                          error_code;
    logic [rhbp_pkg::INDEX_W-1:0]        header_index;
    logic [rhbp_pkg::POSITION_BITS-1:0]  key_start;
    logic [rhbp_pkg::POSITION_BITS-1:0]  key_length;
    logic [rhbp_pkg::POSITION_BITS-1:0]  value_start;
    logic [rhbp_pkg::POSITION_BITS-1:0]  value_length;
    logic [rhbp_pkg::POSITION_BITS-1:0]  bytes_consumed;
    logic                                last_of_run;

    modport source (
        output valid, output result_kind, output error_code, output header_index,
        output key_start, output key_length, output value_start, output value_length,
        output bytes_consumed, output last_of_run, input ready
    );
    modport sink (
        input valid, input result_kind, input error_code, input header_index,
        input key_start, input key_length, input value_start, input value_length,
        input bytes_consumed, input last_of_run, output ready
    );
endinterface

// ===== hdl/rhbp_core.sv =====
// input register and per-byte line parser producing up to two results
`timescale 1ns / 1ps

module rhbp_core (
    input  logic                          clk,
    input  logic                          rst_n,
    rhbp_stream_if.sink                   stream,
    input  logic [rhbp_pkg::CAP_W-1:0]    capacity,
    input  rhbp_pkg::fifo_status_t        status,
    output rhbp_pkg::fifo_push_t          push,
    output rhbp_pkg::result_t             first,
    output rhbp_pkg::result_t             second
);

    localparam int PB = rhbp_pkg::POSITION_BITS;
    localparam int PW = rhbp_pkg::POS_W;
    localparam int CW = rhbp_pkg::CAP_W;

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_eob_reg;

    rhbp_pkg::phase_t     phase_reg, phase_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [PB-1:0]        line_start_reg, line_start_next;
    logic [PB-1:0]        colon_pos_reg, colon_pos_next;
    logic                 colon_seen_reg, colon_seen_next;
    logic                 space_ok_reg, space_ok_next;
    logic [CW-1:0]        emitted_reg, emitted_next;

    logic                 accept;
    logic                 proc;
    logic [PB-1:0]        pos_low;
    logic [PB-1:0]        cr_pos;
    logic [PB-1:0]        colon_dist;
    logic [CW-1:0]        cap_eff;
    logic                 too_long;
    logic                 is_cr;
    logic                 is_lf;
    logic                 blank;
    logic                 line_ok;
    logic                 full;
    logic                 good_record;
    logic                 emit0;
    logic                 emit1;

    assign proc         = in_valid_reg && status.room;
    assign stream.ready = !in_valid_reg || status.room;
    assign accept       = stream.valid && stream.ready;
    assign in_valid_next = accept || (in_valid_reg && !proc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= stream.data_byte;
            in_eob_reg  <= stream.end_of_buffer;
        end
    end

    // line checks on the registered byte
    assign pos_low    = pos_reg[PB-1:0];
    assign cr_pos     = pos_low - PB'(1);
    assign colon_dist = cr_pos - colon_pos_reg;
    assign cap_eff    = (capacity > rhbp_pkg::CAP_MAX) ? rhbp_pkg::CAP_MAX : capacity;
    assign too_long   = pos_reg >= rhbp_pkg::POS_LIMIT;
    assign is_cr      = in_byte_reg == rhbp_pkg::CH_CR;
    assign is_lf      = in_byte_reg == rhbp_pkg::CH_LF;
    assign blank      = cr_pos == line_start_reg;
    assign line_ok    = colon_seen_reg && (colon_pos_reg > line_start_reg) && space_ok_reg
                        && (colon_dist > PB'(rhbp_pkg::VALUE_GAP));
    assign full       = emitted_reg >= cap_eff;
    assign good_record = is_lf && !blank && line_ok && !full;

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        line_start_next = line_start_reg;
        colon_pos_next  = colon_pos_reg;
        colon_seen_next = colon_seen_reg;
        space_ok_next   = space_ok_reg;
        emitted_next    = emitted_reg;
        pos_next        = (pos_reg < rhbp_pkg::POS_STOP) ? pos_reg + PW'(1) : pos_reg;
        if (phase_reg != rhbp_pkg::PH_DONE && too_long)
        begin
            phase_next = rhbp_pkg::PH_DONE;
        end
        else
        begin
            unique case (phase_reg)
                rhbp_pkg::PH_LINE:
                begin
                    if (is_cr)
                    begin
                        phase_next = rhbp_pkg::PH_CR;
                    end
                    else
                    begin
                        if (colon_seen_reg && pos_low == colon_pos_reg + PB'(1)
                            && in_byte_reg == rhbp_pkg::CH_SPACE)
                        begin
                            space_ok_next = 1'b1;
                        end
                        if (!colon_seen_reg && in_byte_reg == rhbp_pkg::CH_COLON)
                        begin
                            colon_seen_next = 1'b1;
                            colon_pos_next  = pos_low;
                        end
                    end
                end
                rhbp_pkg::PH_CR:
                begin
                    if (good_record)
                    begin
                        emitted_next    = emitted_reg + CW'(1);
                        line_start_next = pos_low + PB'(1);
                        colon_seen_next = 1'b0;
                        space_ok_next   = 1'b0;
                        colon_pos_next  = '0;
                        phase_next      = rhbp_pkg::PH_LINE;
                    end
                    else
                    begin
                        phase_next = rhbp_pkg::PH_DONE;
                    end
                end
                rhbp_pkg::PH_DONE:
                begin
                    phase_next = rhbp_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = rhbp_pkg::PH_DONE;
                end
            endcase
        end
        // last byte of the buffer always returns to a fresh block
        if (in_eob_reg)
        begin
            phase_next      = rhbp_pkg::PH_LINE;
            pos_next        = '0;
            line_start_next = '0;
            colon_pos_next  = '0;
            colon_seen_next = 1'b0;
            space_ok_next   = 1'b0;
            emitted_next    = '0;
        end
    end

    // results for this byte
    always_comb
    begin
        emit0  = 1'b0;
        emit1  = 1'b0;
        first  = rhbp_pkg::make_error(rhbp_pkg::ERR_NONE);
        second = rhbp_pkg::make_error(rhbp_pkg::ERR_MISSING_CRLF);
        if (phase_reg != rhbp_pkg::PH_DONE && too_long)
        begin
            emit0 = 1'b1;
            first = rhbp_pkg::make_error(rhbp_pkg::ERR_TOO_LONG);
        end
        else
        begin
            unique case (phase_reg)
                rhbp_pkg::PH_LINE:
                begin
                    if (in_eob_reg)
                    begin
                        emit0 = 1'b1;
                        first = rhbp_pkg::make_error(rhbp_pkg::ERR_NOT_ENOUGH_DATA);
                    end
                end
                rhbp_pkg::PH_CR:
                begin
                    emit0 = 1'b1;
                    if (!is_lf)
                    begin
                        first = rhbp_pkg::make_error(rhbp_pkg::ERR_MISSING_CRLF);
                    end
                    else if (blank)
                    begin
                        first                = '0;
                        first.result_kind    = rhbp_pkg::KIND_DONE;
                        first.error_code     = rhbp_pkg::ERR_NONE;
                        first.bytes_consumed = pos_low + PB'(1);
                    end
                    else if (!line_ok)
                    begin
                        first = rhbp_pkg::make_error(rhbp_pkg::ERR_INVALID_HEADER);
                    end
                    else if (full)
                    begin
                        first = rhbp_pkg::make_error(rhbp_pkg::ERR_EXCESS_HEADERS);
                    end
                    else
                    begin
                        first              = '0;
                        first.result_kind  = rhbp_pkg::KIND_HEADER;
                        first.error_code   = rhbp_pkg::ERR_NONE;
                        first.header_index = emitted_reg[rhbp_pkg::INDEX_W-1:0];
                        first.key_start    = line_start_reg;
                        first.key_length   = colon_pos_reg - line_start_reg;
                        first.value_start  = colon_pos_reg + PB'(rhbp_pkg::VALUE_GAP);
                        first.value_length = colon_dist - PB'(rhbp_pkg::VALUE_GAP);
                        // buffer ends right after a header line
                        emit1 = in_eob_reg;
                    end
                end
                rhbp_pkg::PH_DONE:
                begin
                    emit0 = 1'b0;
                end
                default:
                begin
                    emit0 = 1'b0;
                end
            endcase
        end
        first.last_of_run  = !emit1;
        second.last_of_run = 1'b1;
    end

    assign push.push0 = proc && emit0;
    assign push.push1 = proc && emit1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rhbp_pkg::PH_LINE;
            pos_reg        <= '0;
            line_start_reg <= '0;
            colon_pos_reg  <= '0;
            colon_seen_reg <= 1'b0;
            space_ok_reg   <= 1'b0;
            emitted_reg    <= '0;
        end
        else if (proc)
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            line_start_reg <= line_start_next;
            colon_pos_reg  <= colon_pos_next;
            colon_seen_reg <= colon_seen_next;
            space_ok_reg   <= space_ok_next;
            emitted_reg    <= emitted_next;
        end
    end

endmodule

// ===== hdl/rhbp_result_fifo.sv =====
// result register queue, takes up to two results a cycle and hands out one
`timescale 1ns / 1ps

module rhbp_result_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rhbp_pkg::fifo_push_t    push,
    input  rhbp_pkg::result_t       first,
    input  rhbp_pkg::result_t       second,
    output rhbp_pkg::fifo_status_t  status,
    rhbp_result_if.source           result
);

    localparam int AW = rhbp_pkg::FIFO_AW;
    localparam int CW = rhbp_pkg::FIFO_CW;

    rhbp_pkg::result_t  entry_reg [rhbp_pkg::FIFO_DEPTH];
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         n_push;
    logic               pop;
    rhbp_pkg::result_t  head;

    assign n_push = {1'b0, push.push0} + {1'b0, push.push1};
    assign pop    = result.valid && result.ready;

    // room for two more, ignoring a pop in the same cycle
    assign status.room = count_reg <= CW'(rhbp_pkg::FIFO_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + AW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(n_push) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[wr_ptr_reg] <= first;
        end
        if (push.push1)
        begin
            entry_reg[wr_ptr_reg + AW'(1)] <= second;
        end
    end

    assign head = entry_reg[rd_ptr_reg];

    assign result.valid          = count_reg != '0;
    assign result.result_kind    = head.result_kind;
    assign result.error_code     = head.error_code;
    assign result.header_index   = head.header_index;
    assign result.key_start      = head.key_start;
    assign result.key_length     = head.key_length;
    assign result.value_start    = head.value_start;
    assign result.value_length   = head.value_length;
    assign result.bytes_consumed = head.bytes_consumed;
    assign result.last_of_run    = head.last_of_run;

endmodule

// ===== hdl/rtsp_header_block_parser_unit.sv =====
// top level of the rtsp header block parser
//
// stream carries one byte of header text per item, with end_of_buffer set on
// the buffer's last byte. result carries header records, the done result of a
// blank line, and errors; last_of_run marks the final result caused by a byte.
// header_capacity_we / header_capacity_data write the record capacity register
// (values above 64 act as 64); it must be written only while the block is idle,
// which the block itself does not enforce. a result passes the input register,
// then parse logic into the result queue, before it is valid on result.
// throughput: one byte per cycle while the queue has room for two results; a
// byte that causes two results (a record and missing_crlf at the end of the
// buffer) is handed out as two items by the single-read result queue.
// reset clears the parse state, empties the queue and sets capacity to 16.
// when the receiver stalls, results wait in a four-entry queue; the byte
// stage stops once fewer than two entries are free, and stream.ready drops
// as soon as the input register is also full.
`timescale 1ns / 1ps

module rtsp_header_block_parser_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    rhbp_stream_if.sink                   stream,
    rhbp_result_if.source                 result,
    input  logic                          header_capacity_we,
    input  logic [rhbp_pkg::CAP_W-1:0]    header_capacity_data
);

    logic [rhbp_pkg::CAP_W-1:0] capacity_reg;
    rhbp_pkg::fifo_status_t     status;
    rhbp_pkg::fifo_push_t       push;
    rhbp_pkg::result_t          first;
    rhbp_pkg::result_t          second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= rhbp_pkg::CAP_RESET;
        end
        else if (header_capacity_we)
        begin
            capacity_reg <= header_capacity_data;
        end
    end

    rhbp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .capacity (capacity_reg),
        .status   (status),
        .push     (push),
        .first    (first),
        .second   (second)
    );

    rhbp_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .first  (first),
        .second (second),
        .status (status),
        .result (result)
    );

endmodule

// ===== hdl/rhbp_checker.sv =====
// port-level checks on the parser top level, with its bind
`timescale 1ns / 1ps

module rhbp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic [1:0]                         res_kind,
    input logic [2:0]                         res_error,
    input logic [rhbp_pkg::INDEX_W-1:0]       res_index,
    input logic [rhbp_pkg::POSITION_BITS-1:0] res_key_start,
    input logic [rhbp_pkg::POSITION_BITS-1:0] res_key_length,
    input logic [rhbp_pkg::POSITION_BITS-1:0] res_bytes,
    input logic                               res_last
);

    // a waiting item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped while stalled");

    // errors carry a code and no record fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == rhbp_pkg::KIND_ERROR |->
        res_error != rhbp_pkg::ERR_NONE && res_index == '0 && res_key_start == '0
        && res_key_length == '0 && res_bytes == '0)
        else $error("error item carries record fields");

    // records have a non-empty key and no error code
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == rhbp_pkg::KIND_HEADER |->
        res_error == rhbp_pkg::ERR_NONE && res_key_length != '0 && res_bytes == '0)
        else $error("malformed header record item");

    // done stands alone for its byte and counts at least the blank line
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == rhbp_pkg::KIND_DONE |->
        res_last && res_error == rhbp_pkg::ERR_NONE && res_bytes >= 2)
        else $error("malformed done item");

endmodule

bind rtsp_header_block_parser_unit rhbp_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_kind       (result.result_kind),
    .res_error      (result.error_code),
    .res_index      (result.header_index),
    .res_key_start  (result.key_start),
    .res_key_length (result.key_length),
    .res_bytes      (result.bytes_consumed),
    .res_last       (result.last_of_run)
);

// ===== dv/rhbp_result_checker.sv =====
// result checker for the rtsp header block parser: byte-level parse prediction and comparison
`timescale 1ns / 1ps

module rhbp_result_checker
    import rhbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rhbp_stream_if             stream,
    rhbp_result_if             result,
    input  logic               header_capacity_we,
    input  logic [CAP_W-1:0]   header_capacity_data,
    output int                 mismatches,
    output int                 outstanding
);

    // parse state mirrored from the byte stream
    logic [CAP_W-1:0]   capacity;
    logic [POS_W-1:0]   byte_pos;
    logic [POS_W-1:0]   line_start;
    logic [POS_W-1:0]   colon_pos;
    logic               colon_seen;
    logic               space_ok;
    phase_t             phase;
    logic [CAP_W-1:0]   records_out;

    result_t            predicted_results[$];
    result_t            from_byte[2];
    int                 from_byte_n;
    int                 fail_count;

    assign mismatches = fail_count;

    task automatic clear_block();
        byte_pos    = '0;
        line_start  = '0;
        colon_pos   = '0;
        colon_seen  = 1'b0;
        space_ok    = 1'b0;
        phase       = PH_LINE;
        records_out = '0;
    endtask

    task automatic add_error(input error_t code);
        result_t item;
        item = '0;
        item.result_kind = KIND_ERROR;
        item.error_code  = code;
        from_byte[from_byte_n] = item;
        from_byte_n++;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eob);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] cr_pos;
        logic [CAP_W-1:0] cap_eff;
        result_t          rec;
        pos = byte_pos;
        cap_eff = (capacity > CAP_MAX) ? CAP_MAX : capacity;
        from_byte_n = 0;
        if (phase == PH_DONE)
        begin
            // block already ended, byte ignored
        end
        else if (pos >= POS_LIMIT)
        begin
            add_error(ERR_TOO_LONG);
            phase = PH_DONE;
        end
        else if (phase == PH_LINE)
        begin
            if (b == CH_CR)
            begin
                if (eob)
                    add_error(ERR_NOT_ENOUGH_DATA);
                else
                    phase = PH_CR;
            end
            else
            begin
                if (colon_seen && pos == colon_pos + 1 && b == CH_SPACE)
                    space_ok = 1'b1;
                if (!colon_seen && b == CH_COLON)
                begin
                    colon_seen = 1'b1;
                    colon_pos  = pos;
                end
                if (eob)
                    add_error(ERR_NOT_ENOUGH_DATA);
            end
        end
        else if (b != CH_LF)
        begin
            add_error(ERR_MISSING_CRLF);
            phase = PH_DONE;
        end
        else
        begin
            cr_pos = pos - 1;
            if (cr_pos == line_start)
            begin
                rec = '0;
                rec.result_kind    = KIND_DONE;
                rec.error_code     = ERR_NONE;
                rec.bytes_consumed = POSITION_BITS'(pos + 1);
                from_byte[0] = rec;
                from_byte_n  = 1;
                phase = PH_DONE;
            end
            else if (!(colon_seen && colon_pos > line_start && space_ok &&
                       (cr_pos - colon_pos) > VALUE_GAP))
            begin
                add_error(ERR_INVALID_HEADER);
                phase = PH_DONE;
            end
            else if (records_out >= cap_eff)
            begin
                add_error(ERR_EXCESS_HEADERS);
                phase = PH_DONE;
            end
            else
            begin
                rec = '0;
                rec.result_kind  = KIND_HEADER;
                rec.error_code   = ERR_NONE;
                rec.header_index = records_out[INDEX_W-1:0];
                rec.key_start    = line_start[POSITION_BITS-1:0];
                rec.key_length   = POSITION_BITS'(colon_pos - line_start);
                rec.value_start  = POSITION_BITS'(colon_pos + VALUE_GAP);
                rec.value_length = POSITION_BITS'(cr_pos - colon_pos - VALUE_GAP);
                from_byte[0] = rec;
                from_byte_n  = 1;
                records_out  = records_out + 1;
                line_start   = pos + 1;
                colon_seen   = 1'b0;
                space_ok     = 1'b0;
                colon_pos    = '0;
                phase        = PH_LINE;
                // buffer ran out right after a header line
                if (eob)
                    add_error(ERR_MISSING_CRLF);
            end
        end
        if (byte_pos <= POS_LIMIT)
            byte_pos = pos + 1;
        if (eob)
            clear_block();
        if (from_byte_n > 0)
            from_byte[from_byte_n-1].last_of_run = 1'b1;
        for (int i = 0; i < from_byte_n; i++)
            predicted_results.push_back(from_byte[i]);
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            capacity = CAP_RESET;
            clear_block();
            predicted_results.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result_kind: expected no result, got %0d", result.result_kind);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("result_kind", want.result_kind, result.result_kind);
                    check_field("error_code", want.error_code, result.error_code);
                    check_field("header_index", want.header_index, result.header_index);
                    check_field("key_start", want.key_start, result.key_start);
                    check_field("key_length", want.key_length, result.key_length);
                    check_field("value_start", want.value_start, result.value_start);
                    check_field("value_length", want.value_length, result.value_length);
                    check_field("bytes_consumed", want.bytes_consumed,
                                result.bytes_consumed);
                    check_field("last_of_run", want.last_of_run, result.last_of_run);
                end
            end
            if (stream.valid && stream.ready)
                parse_byte(stream.data_byte, stream.end_of_buffer);
            if (header_capacity_we)
                capacity = header_capacity_data;
            outstanding <= predicted_results.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// top of the rtsp header block parser testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import rhbp_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               header_capacity_we;
    logic [CAP_W-1:0]   header_capacity_data;
    int                 mismatches;
    int                 outstanding;

    int                 send_idle_pct;
    int                 sink_idle_pct;
    int                 current_cap;
    logic [7:0]         block_text[$];

    rhbp_stream_if stream_ch();
    rhbp_result_if result_ch();

    rtsp_header_block_parser_unit DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .stream               (stream_ch),
        .result               (result_ch),
        .header_capacity_we   (header_capacity_we),
        .header_capacity_data (header_capacity_data)
    );

    rhbp_result_checker checker_inst (
        .clk                  (clk),
        .rst_n                (rst_n),
        .stream               (stream_ch),
        .result               (result_ch),
        .header_capacity_we   (header_capacity_we),
        .header_capacity_data (header_capacity_data),
        .mismatches           (mismatches),
        .outstanding          (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("testbench: done, errors");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        result_ch.ready <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < sink_idle_pct)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] key_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0)
            c = 8'($urandom_range(128, 255));
        else
        begin
            c = 8'($urandom_range(33, 126));
            if (c == CH_COLON)
                c = "k";
        end
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 9))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_COLON;
            3: return CH_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            block_text.push_back(s[i]);
    endtask

    task automatic add_crlf();
        block_text.push_back(CH_CR);
        block_text.push_back(CH_LF);
    endtask

    task automatic add_header(input int key_len, input int val_len);
        repeat (key_len) block_text.push_back(key_char());
        block_text.push_back(CH_COLON);
        block_text.push_back(CH_SPACE);
        repeat (val_len) block_text.push_back(value_char());
        add_crlf();
    endtask

    task automatic add_bad_line();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:
            begin
                // no colon at all
                repeat ($urandom_range(1, 5)) block_text.push_back(key_char());
            end
            1:
            begin
                // empty key
                block_text.push_back(CH_COLON);
                block_text.push_back(CH_SPACE);
                repeat ($urandom_range(1, 4)) block_text.push_back(value_char());
            end
            2:
            begin
                // no space after the colon
                repeat ($urandom_range(1, 4)) block_text.push_back(key_char());
                block_text.push_back(CH_COLON);
                do
                    c = value_char();
                while (c == CH_SPACE);
                block_text.push_back(c);
                repeat ($urandom_range(0, 3)) block_text.push_back(value_char());
            end
            default:
            begin
                // empty value
                repeat ($urandom_range(1, 4)) block_text.push_back(key_char());
                block_text.push_back(CH_COLON);
                block_text.push_back(CH_SPACE);
            end
        endcase
        add_crlf();
    endtask

    task automatic build_random_block(input int cap_eff, input bit fill_capacity);
        int         header_count;
        logic [7:0] c;
        if (!fill_capacity && $urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 12)) block_text.push_back(noise_char());
            return;
        end
        if (fill_capacity || $urandom_range(0, 9) == 0)
            header_count = cap_eff + $urandom_range(fill_capacity ? 2 : 0, 2);
        else
            header_count = $urandom_range(0, 4);
        for (int i = 0; i < header_count; i++)
        begin
            if (header_count > 8)
                add_header(1, 1);
            else
                add_header($urandom_range(1, 5), $urandom_range(1, 6));
        end
        if (fill_capacity)
        begin
            add_crlf();
            return;
        end
        case ($urandom_range(0, 7))
            0, 1, 2: add_crlf();
            3:
            begin
                add_crlf();
                repeat ($urandom_range(1, 3)) block_text.push_back(noise_char());
            end
            4:
            begin
                // buffer ends inside a line, sometimes on its CR
                repeat ($urandom_range(1, 3)) block_text.push_back(key_char());
                if ($urandom_range(0, 1))
                begin
                    block_text.push_back(CH_COLON);
                    block_text.push_back(CH_SPACE);
                    repeat ($urandom_range(0, 3)) block_text.push_back(value_char());
                end
                if ($urandom_range(0, 1))
                    block_text.push_back(CH_CR);
            end
            5:
            begin
                // buffer ends right after a header line
                if (header_count == 0)
                    add_header(1, $urandom_range(1, 3));
            end
            6:
            begin
                add_bad_line();
                repeat ($urandom_range(0, 2)) block_text.push_back(noise_char());
            end
            default:
            begin
                block_text.push_back(CH_CR);
                do
                    c = noise_char();
                while (c == CH_LF);
                block_text.push_back(c);
                repeat ($urandom_range(0, 2)) block_text.push_back(noise_char());
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eob);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            stream_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        stream_ch.valid         <= 1'b1;
        stream_ch.data_byte     <= b;
        stream_ch.end_of_buffer <= eob;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_block();
        for (int i = 0; i < block_text.size(); i++)
            send_byte(block_text[i], i == block_text.size() - 1);
        block_text.delete();
    endtask

    // hold the stream until every predicted result is out and the pipe is empty
    task automatic drain();
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input int cap);
        header_capacity_we   <= 1'b1;
        header_capacity_data <= CAP_W'(cap);
        @(posedge clk);
        header_capacity_we   <= 1'b0;
        current_cap = cap;
    endtask

    // one long header, then a line that runs past the position limit
    task automatic send_long_block();
        send_byte("k", 1'b0);
        send_byte(CH_COLON, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        for (int p = 3; p < 60003; p++)
            send_byte(value_char(), 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        for (int p = 60005; p <= 65538; p++)
            send_byte("x", p == 65538);
    endtask

    initial
    begin
        int phase_caps[7];
        int cap_eff;
        int phase_bytes;
        bit last_phase;

        rst_n                   <= 1'b0;
        stream_ch.valid         <= 1'b0;
        stream_ch.data_byte     <= '0;
        stream_ch.end_of_buffer <= 1'b0;
        header_capacity_we      <= 1'b0;
        header_capacity_data    <= '0;
        send_idle_pct = 10;
        sink_idle_pct = 5;
        current_cap   = CAP_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // record, then buffer ends after its LF; extreme byte values in the value
        add_text("A: ");
        block_text.push_back(8'h00);
        block_text.push_back(8'hFF);
        add_crlf();
        send_block();
        // blank line, then an ignored byte
        add_crlf();
        add_text("z");
        send_block();
        // buffer ends mid-line and on a CR
        add_text("a");
        send_block();
        block_text.push_back(CH_CR);
        send_block();
        // CR without LF
        block_text.push_back(CH_CR);
        add_text("X");
        send_block();
        // malformed lines
        add_text(":");
        add_crlf();
        send_block();
        add_text("a");
        add_crlf();
        send_block();
        add_text("a:b");
        add_crlf();
        send_block();
        add_text("a: ");
        add_crlf();
        send_block();

        drain();
        send_idle_pct = 0;
        send_long_block();

        phase_caps[0] = CAP_RESET;
        phase_caps[1] = 0;
        phase_caps[2] = 1;
        phase_caps[3] = MAX_HEADERS;
        phase_caps[4] = 127;
        phase_caps[5] = $urandom_range(2, MAX_HEADERS - 1);
        phase_caps[6] = $urandom_range(0, 127);

        for (int ph = 0; ph < 7; ph++)
        begin
            last_phase = (ph == 6);
            drain();
            if (ph > 0)
                write_capacity(phase_caps[ph]);
            cap_eff = (current_cap > MAX_HEADERS) ? MAX_HEADERS : current_cap;
            if (last_phase)
            begin
                send_idle_pct = 0;
                sink_idle_pct = 0;
            end
            phase_bytes = 0;
            if (cap_eff == MAX_HEADERS)
            begin
                build_random_block(cap_eff, 1'b1);
                phase_bytes += block_text.size();
                send_block();
            end
            while (phase_bytes < 195)
            begin
                if (!last_phase)
                begin
                    case ($urandom_range(0, 3))
                        0, 1: send_idle_pct = 0;
                        2:    send_idle_pct = 4;
                        default: send_idle_pct = 20;
                    endcase
                    case ($urandom_range(0, 3))
                        0, 1: sink_idle_pct = 0;
                        2:    sink_idle_pct = 2;
                        default: sink_idle_pct = 8;
                    endcase
                end
                build_random_block(cap_eff, 1'b0);
                phase_bytes += block_text.size();
                send_block();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rhbp_pkg.sv
hdl/rhbp_stream_if.sv
hdl/rhbp_result_if.sv
hdl/rhbp_core.sv
hdl/rhbp_result_fifo.sv
hdl/rtsp_header_block_parser_unit.sv
hdl/rhbp_checker.sv
dv/rhbp_result_checker.sv
dv/testbench.sv
